// File: hw/rtl/mceb_pkg.sv
// mceb_pkg: shared constants and types for the multi-channel event barrier
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package mceb_pkg;

   localparam int CHANNELS_DEFAULT = 8;
   localparam int CHANNEL_MAX      = 64;

   localparam int KIND_W    = 2;
   localparam int CHANNEL_W = 6;
   localparam int COUNT_W   = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
   localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(1);

   // request kinds, code 3 means nothing and is dropped
   typedef enum logic [KIND_W-1:0] {
      REQ_EVENT = 2'd0,
      REQ_LIMIT = 2'd1,
      REQ_COUNT = 2'd2
   } req_kind_type;

endpackage

`default_nettype wire

// File: hw/rtl/mceb_req_if.sv
// mceb_req_if: request channel (valid/ready) carrying one barrier transaction
// depends on mceb_pkg for field widths
`default_nettype none

interface mceb_req_if;
   logic                           valid;
   logic                           ready;
   logic [mceb_pkg::KIND_W-1:0]    req_type;
   logic [mceb_pkg::CHANNEL_W-1:0] channel;
   logic [mceb_pkg::COUNT_W-1:0]   value;

   modport source (output valid, output req_type, output channel, output value,
                   input ready);
   modport sink   (input valid, input req_type, input channel, input value,
                   output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mceb_rsp_if.sv
// mceb_rsp_if: response channel (valid/ready) carrying one reported count
// depends on mceb_pkg for field widths
`default_nettype none

interface mceb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mceb_pkg::CHANNEL_W-1:0] channel_res;
   logic [mceb_pkg::COUNT_W-1:0]   count;
   logic                           fire;
   logic                           last;

   modport source (output valid, output channel_res, output count, output fire,
                   output last, input ready);
   modport sink   (input valid, input channel_res, input count, input fire,
                   input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/multi_channel_event_barrier.sv
// Event barrier over CHANNELS channels, each with a 16-bit count, a 16-bit
// limit and a satisfied flag (count >= limit). A request is processed in the
// cycle it is accepted and its response sits in a single output register, so
// a new request is taken every cycle while that register drains or is free.
// A count write updates state but gives no response. When an event or limit
// write satisfies the last unsatisfied channel the barrier fires: all counts
// clear at once and CHANNELS zero-count responses follow from the highest
// channel down, one per cycle from the output register while the receiver
// takes them; fire and last mark the one for channel 0. During that burst
// the request side is held off. Requests for a channel at or above CHANNELS,
// or of the unused kind, are accepted and dropped. Depends on mceb_pkg,
// mceb_req_if and mceb_rsp_if.
`default_nettype none

module multi_channel_event_barrier #(
   parameter int CHANNELS = mceb_pkg::CHANNELS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   mceb_req_if.sink        req,
   mceb_rsp_if.source      rsp
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int TOT_W = $clog2(CHANNELS + 1);
   localparam int CW    = mceb_pkg::CHANNEL_W;
   localparam int VW    = mceb_pkg::COUNT_W;

   localparam logic [IDX_W-1:0] IDX_TOP   = IDX_W'(CHANNELS - 1);
   localparam logic [TOT_W-1:0] TOT_OTHER = TOT_W'(CHANNELS - 1);
   localparam logic [TOT_W-1:0] TOT_ALL   = TOT_W'(CHANNELS);
   localparam logic [CW:0]      CH_LIMIT  = (CW + 1)'(CHANNELS);

   // channel state
   logic [VW-1:0]    counts_ff [CHANNELS];
   logic [VW-1:0]    counts_in [CHANNELS];
   logic [VW-1:0]    limits_ff [CHANNELS];
   logic [VW-1:0]    limits_in [CHANNELS];
   logic [CHANNELS-1:0] sat_ff;
   logic [CHANNELS-1:0] sat_in;
   logic [TOT_W-1:0] total_ff;
   logic [TOT_W-1:0] total_in;

   // output register and firing burst
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]    rsp_channel_ff, rsp_channel_in;
   logic [VW-1:0]    rsp_count_ff, rsp_count_in;
   logic             rsp_fire_ff, rsp_fire_in;
   logic [IDX_W-1:0] burst_ff, burst_in;
   logic [IDX_W-1:0] burst_next;

   // marks responses that belong to a firing burst
   logic             burst_resp_ff, burst_resp_in;

   mceb_pkg::req_kind_type kind;
   logic             slot_free;
   logic             accept;
   logic             in_range;
   logic             kind_ok;
   logic [IDX_W-1:0] idx;
   logic [VW-1:0]    cur_count, cur_limit, new_count, new_limit;
   logic             cur_sat, now_sat, rose, fell;
   logic             others_done;
   logic             do_fire, emit;

   assign kind      = mceb_pkg::req_kind_type'(req.req_type);
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (burst_ff == '0) && slot_free;
   assign accept    = req.valid && req.ready;
   assign in_range  = {1'b0, req.channel} < CH_LIMIT;
   assign idx       = req.channel[IDX_W-1:0];
   assign cur_count = counts_ff[idx];
   assign cur_limit = limits_ff[idx];
   assign cur_sat   = sat_ff[idx];
   assign others_done = total_ff >= TOT_OTHER;
   assign burst_next  = burst_ff - IDX_W'(1);

   always_comb begin
      new_count = cur_count;
      new_limit = cur_limit;
      kind_ok   = 1'b1;
      unique case (kind)
         mceb_pkg::REQ_EVENT: begin
            if (cur_count != mceb_pkg::COUNT_MAX) new_count = cur_count + VW'(1);
         end
         mceb_pkg::REQ_LIMIT: new_limit = req.value;
         mceb_pkg::REQ_COUNT: new_count = req.value;
         default:             kind_ok   = 1'b0;
      endcase
   end

   assign now_sat = new_count >= new_limit;
   assign rose    = now_sat && !cur_sat;
   assign fell    = !now_sat && cur_sat;
   assign do_fire = accept && in_range && kind_ok && (kind != mceb_pkg::REQ_COUNT)
                    && rose && others_done;
   assign emit    = accept && in_range && kind_ok && (kind != mceb_pkg::REQ_COUNT)
                    && !do_fire;

   // state update
   always_comb begin
      counts_in = counts_ff;
      limits_in = limits_ff;
      sat_in    = sat_ff;
      total_in  = total_ff;
      if (accept && in_range && kind_ok) begin
         limits_in[idx] = new_limit;
         if (do_fire) begin
            for (int i = 0; i < CHANNELS; i++) begin
               counts_in[i] = '0;
               sat_in[i]    = (limits_in[i] == '0);
            end
            total_in = TOT_W'($countones(sat_in));
         end else begin
            counts_in[idx] = new_count;
            sat_in[idx]    = now_sat;
            if (rose) total_in = total_ff + TOT_W'(1);
            else if (fell) total_in = total_ff - TOT_W'(1);
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_channel_in = rsp_channel_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_fire_in    = rsp_fire_ff;
      burst_in       = burst_ff;
      priority if (do_fire) begin
         rsp_valid_in   = 1'b1;
         rsp_channel_in = CW'(IDX_TOP);
         rsp_count_in   = '0;
         rsp_fire_in    = 1'b0;
         burst_in       = IDX_TOP;
      end else if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_channel_in = req.channel;
         rsp_count_in   = new_count;
         rsp_fire_in    = 1'b0;
      end else if (burst_ff != '0 && slot_free) begin
         rsp_valid_in   = 1'b1;
         rsp_channel_in = CW'(burst_next);
         rsp_count_in   = '0;
         rsp_fire_in    = (burst_next == '0);
         burst_in       = burst_next;
      end else if (rsp.ready) begin
         rsp_valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            counts_ff[i] <= '0;
            limits_ff[i] <= mceb_pkg::LIMIT_RESET;
         end
         sat_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         burst_ff     <= '0;
      end else begin
         counts_ff    <= counts_in;
         limits_ff    <= limits_in;
         sat_ff       <= sat_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         burst_ff     <= burst_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_channel_ff <= rsp_channel_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_fire_ff    <= rsp_fire_in;
   end

   always_comb begin
      burst_resp_in = burst_resp_ff;
      if (do_fire) burst_resp_in = 1'b1;
      else if (emit) burst_resp_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) burst_resp_ff <= 1'b0;
      else       burst_resp_ff <= burst_resp_in;
   end

   // fire only ever rides on the final burst response, so it doubles as last
   // there; ordinary responses are always last
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.channel_res = rsp_channel_ff;
   assign rsp.count       = rsp_count_ff;
   assign rsp.fire        = rsp_fire_ff;
   assign rsp.last        = rsp_fire_ff || !burst_resp_ff;

   // no transaction is taken while a firing burst is still draining
   assert property (@(posedge clock) disable iff (reset)
      (burst_ff != '0) |-> !(req.valid && req.ready))
      else $error("request accepted during firing burst");

   // fire appears only on the channel 0 response, which also ends the transaction
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.fire) |-> (rsp.channel_res == '0 && rsp.last && rsp.count == '0))
      else $error("fire on a response other than the final one");

   // satisfied total tracks the flags
   assert property (@(posedge clock) disable iff (reset)
      total_ff == TOT_W'($countones(sat_ff)) && total_ff <= TOT_ALL)
      else $error("satisfied total out of step with flags");

endmodule

`default_nettype wire

// File: bench/multi_channel_event_barrier_test.sv
`timescale 1ns / 1ps
// multi_channel_event_barrier_test: self-checking bench for the event barrier
// drives mceb_req_if, checks every mceb_rsp_if transaction against table or predictor
// depends on mceb_pkg, mceb_req_if, mceb_rsp_if and multi_channel_event_barrier

module multi_channel_event_barrier_test;

   localparam int CHANNELS     = 8;
   localparam int RANDOM_ITEMS = 343;
   localparam int STALL_LIMIT  = 4000;
   localparam int MAX_REPORTED = 10;

   localparam int KW = mceb_pkg::KIND_W;
   localparam int CW = mceb_pkg::CHANNEL_W;
   localparam int VW = mceb_pkg::COUNT_W;

   // expectation codes in the stimulus table
   localparam int FROM_MODEL = -1;
   localparam int NO_REPORT  = -2;

   localparam logic [KW-1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [CW-1:0] channel;
      logic [VW-1:0] count;
      logic          fire;
      logic          last;
   } barrier_report_type;

   typedef struct {
      logic [KW-1:0] kind;
      logic [CW-1:0] channel;
      logic [VW-1:0] value;
      int            want;
   } stim_row_type;

   logic clock;
   logic reset;

   mceb_req_if req_ch ();
   mceb_rsp_if rsp_ch ();

   multi_channel_event_barrier #(.CHANNELS(CHANNELS)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // idle percentages per phase: sender gaps, receiver stalls
   int src_gap_pct   [3] = '{31, 78, 0};
   int snk_stall_pct [3] = '{78, 31, 0};
   int phase = 0;
   int mismatches = 0;

   // predictor state
   logic [VW-1:0] ch_count [CHANNELS];
   logic [VW-1:0] ch_limit [CHANNELS];
   bit            ch_sat   [CHANNELS];
   int            sat_total;

   barrier_report_type expected_reports [$];

   stim_row_type directed_rows [27] = '{
      '{mceb_pkg::REQ_EVENT,  0, 16'h0000, 1},
      '{mceb_pkg::REQ_EVENT,  7, 16'hFFFF, 1},
      '{REQ_UNUSED,           1, 16'h1234, NO_REPORT},
      '{mceb_pkg::REQ_EVENT, 63, 16'h0000, NO_REPORT},
      '{mceb_pkg::REQ_LIMIT,  1, 16'h0000, 0},
      '{mceb_pkg::REQ_COUNT,  2, 16'hFFFF, NO_REPORT},
      '{mceb_pkg::REQ_EVENT,  2, 16'h0000, 65535},
      '{mceb_pkg::REQ_LIMIT,  3, 16'hFFFF, 0},
      '{mceb_pkg::REQ_COUNT,  3, 16'hFFFE, NO_REPORT},
      '{mceb_pkg::REQ_EVENT,  3, 16'h0000, 65535},
      '{mceb_pkg::REQ_COUNT,  4, 16'h0005, NO_REPORT},
      '{mceb_pkg::REQ_COUNT,  4, 16'h0000, NO_REPORT},
      '{mceb_pkg::REQ_LIMIT,  5, 16'h0000, 0},
      '{mceb_pkg::REQ_COUNT,  6, 16'h1234, NO_REPORT},
      // every channel now satisfied by a count write, which must not fire
      '{mceb_pkg::REQ_COUNT,  4, 16'hAAAA, NO_REPORT},
      '{mceb_pkg::REQ_LIMIT,  4, 16'h5555, 43690},
      '{mceb_pkg::REQ_LIMIT,  4, 16'hFFFF, 43690},
      '{mceb_pkg::REQ_LIMIT,  4, 16'h0001, FROM_MODEL},
      '{mceb_pkg::REQ_LIMIT,  0, 16'h0000, FROM_MODEL},
      '{mceb_pkg::REQ_LIMIT,  2, 16'h0000, FROM_MODEL},
      '{mceb_pkg::REQ_LIMIT,  3, 16'h0000, FROM_MODEL},
      '{mceb_pkg::REQ_LIMIT,  4, 16'h0000, FROM_MODEL},
      '{mceb_pkg::REQ_LIMIT,  6, 16'h0000, FROM_MODEL},
      '{mceb_pkg::REQ_LIMIT,  7, 16'h0000, FROM_MODEL},
      '{mceb_pkg::REQ_EVENT,  0, 16'h0000, FROM_MODEL},
      '{mceb_pkg::REQ_LIMIT,  0, 16'h0002, FROM_MODEL},
      '{mceb_pkg::REQ_EVENT,  0, 16'h0000, FROM_MODEL}
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic bit refresh_flag(int c);
      bit now_sat;
      bit rose;
      now_sat = ch_count[c] >= ch_limit[c];
      rose = now_sat && !ch_sat[c];
      if (rose)
         sat_total++;
      else if (!now_sat && ch_sat[c])
         sat_total--;
      ch_sat[c] = now_sat;
      return rose;
   endfunction

   function automatic void barrier_predict(input logic [KW-1:0] kind,
                                           input logic [CW-1:0] ch,
                                           input logic [VW-1:0] val,
                                           ref barrier_report_type out [$]);
      bit others_done;
      int c;
      c = int'(ch);
      if (c >= CHANNELS)
         return;
      others_done = sat_total + 1 >= CHANNELS;
      case (kind)
         mceb_pkg::REQ_EVENT: begin
            if (ch_count[c] != mceb_pkg::COUNT_MAX)
               ch_count[c] = ch_count[c] + 1'b1;
         end
         mceb_pkg::REQ_LIMIT: ch_limit[c] = val;
         mceb_pkg::REQ_COUNT: begin
            ch_count[c] = val;
            void'(refresh_flag(c));
            return;
         end
         default: return;
      endcase
      if (refresh_flag(c) && others_done) begin
         // barrier fires: clear all, report highest channel first
         sat_total = 0;
         for (int i = CHANNELS - 1; i >= 0; i--) begin
            ch_count[i] = '0;
            ch_sat[i] = (ch_limit[i] == '0);
            if (ch_sat[i])
               sat_total++;
            out.push_back('{CW'(i), '0, i == 0, i == 0});
         end
      end else begin
         out.push_back('{ch, ch_count[c], 1'b0, 1'b1});
      end
   endfunction

   task automatic send_item(input stim_row_type row);
      barrier_report_type predicted [$];
      while ($urandom_range(99) < src_gap_pct[phase]) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid    = 1'b1;
      req_ch.req_type = row.kind;
      req_ch.channel  = row.channel;
      req_ch.value    = row.value;
      do @(posedge clock); while (!req_ch.ready);
      barrier_predict(row.kind, row.channel, row.value, predicted);
      if (row.want == FROM_MODEL)
         foreach (predicted[i]) expected_reports.push_back(predicted[i]);
      else if (row.want != NO_REPORT)
         expected_reports.push_back('{row.channel, VW'(row.want), 1'b0, 1'b1});
      @(negedge clock);
   endtask

   function automatic void log_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTED)
         $display("mismatch: %s", what);
   endfunction

   // response checker
   always @(posedge clock) begin
      barrier_report_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_reports.size() == 0) begin
            log_mismatch($sformatf("unexpected transaction ch=%0d count=%0d fire=%0b last=%0b",
                                   rsp_ch.channel_res, rsp_ch.count, rsp_ch.fire,
                                   rsp_ch.last));
         end else begin
            want = expected_reports.pop_front();
            if (rsp_ch.channel_res !== want.channel || rsp_ch.count !== want.count ||
                rsp_ch.fire !== want.fire || rsp_ch.last !== want.last)
               log_mismatch($sformatf(
                  {"expected ch=%0d count=%0d fire=%0b last=%0b, ",
                   "got ch=%0d count=%0d fire=%0b last=%0b"},
                  want.channel, want.count, want.fire, want.last,
                  rsp_ch.channel_res, rsp_ch.count, rsp_ch.fire, rsp_ch.last));
         end
      end
   end

   // receiver stalls
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = ($urandom_range(99) >= snk_stall_pct[phase]);
      end
   end

   // watchdog on cycles with no transaction on either side
   initial begin
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      stim_row_type row;
      int sent;
      int pick;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.req_type = mceb_pkg::REQ_EVENT;
      req_ch.channel  = '0;
      req_ch.value    = '0;
      sat_total       = 0;
      sent            = 0;
      for (int i = 0; i < CHANNELS; i++) begin
         ch_count[i] = '0;
         ch_limit[i] = mceb_pkg::LIMIT_RESET;
         ch_sat[i]   = 1'b0;
      end
      repeat (10) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) send_item(directed_rows[i]);

      // mostly ticks against small limits so the barrier keeps firing
      while (sent < RANDOM_ITEMS) begin
         phase = (sent * 3) / RANDOM_ITEMS;
         pick = $urandom_range(99);
         row.want    = FROM_MODEL;
         row.kind    = mceb_pkg::REQ_EVENT;
         row.channel = CW'($urandom_range(CHANNELS - 1));
         row.value   = VW'($urandom);
         if (pick >= 90) begin
            if ($urandom_range(1)) begin
               row.kind    = REQ_UNUSED;
               row.channel = CW'($urandom);
            end else begin
               row.kind    = KW'($urandom_range(mceb_pkg::REQ_COUNT));
               row.channel = CW'($urandom_range((1 << CW) - 1, CHANNELS));
            end
         end else if (pick >= 80) begin
            row.kind = mceb_pkg::REQ_COUNT;
            if ($urandom_range(1))
               row.value = VW'($urandom_range(2));
         end else if (pick >= 66) begin
            row.kind = mceb_pkg::REQ_LIMIT;
            if ($urandom_range(3) != 0)
               row.value = VW'($urandom_range(3));
         end
         send_item(row);
         sent++;
      end
      req_ch.valid = 1'b0;

      while (expected_reports.size() != 0) @(posedge clock);
      repeat (2 * CHANNELS + 8) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
